// ===== rtl/lpag_pkg.sv =====
// ----------------------------------------------------------------------------
// lpag_pkg
// Shared widths, codes and the pixel record for the line pixel address
// generator.
// ----------------------------------------------------------------------------
package lpag_pkg;

  localparam int FONT_WIDTH  = 8;   // dots per display RAM byte, 6 to 8
  localparam int COORD_W     = 8;
  localparam int ADDR_W      = 16;
  localparam int ROWB_W      = 8;
  localparam int BITPOS_W    = 3;
  localparam int ERR_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Item commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRAPHIC_HOME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES    = 1'b1;

  localparam logic [ROWB_W-1:0] ROW_BYTES_RESET = 8'd30;

  // One classified pixel between the front and the back
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               color;
    logic               last;
  } pixel_t;

endpackage

// ===== rtl/lpag_front.sv =====
// ----------------------------------------------------------------------------
// lpag_front
// Accepts start and step items, runs the line stepper and pushes one pixel
// record per item into the queue.
// ----------------------------------------------------------------------------
module lpag_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   q_full,
  input  logic                   in_cmd,
  input  logic [lpag_pkg::COORD_W-1:0] in_x_start,
  input  logic [lpag_pkg::COORD_W-1:0] in_y_start,
  input  logic [lpag_pkg::COORD_W-1:0] in_x_end,
  input  logic [lpag_pkg::COORD_W-1:0] in_y_end,
  input  logic                   in_draw_color,
  output logic                   push,
  output lpag_pkg::pixel_t       push_pixel
);
  import lpag_pkg::*;

  logic [COORD_W-1:0] cur_x_r, cur_y_r, goal_x_r, goal_y_r, delta_x_r, delta_y_r;
  logic [COORD_W-1:0] cur_x_nxt, cur_y_nxt, goal_x_nxt, goal_y_nxt;
  logic [COORD_W-1:0] delta_x_nxt, delta_y_nxt;
  logic               step_left_r, step_up_r, x_major_r, line_active_r, held_color_r;
  logic               step_left_nxt, step_up_nxt, x_major_nxt, line_active_nxt;
  logic               held_color_nxt;
  logic signed [ERR_W-1:0] accum_error_r, accum_error_nxt;

  logic [COORD_W-1:0] maj_delta, min_delta;
  logic signed [ERR_W-1:0] err_sum;
  logic               minor_step;

  assign push = in_valid && !q_full;

  // Error update shared by both axis orders
  always_comb begin
    maj_delta  = x_major_r ? delta_x_r : delta_y_r;
    min_delta  = x_major_r ? delta_y_r : delta_x_r;
    err_sum    = accum_error_r + $signed({2'b00, min_delta, 1'b0});
    minor_step = err_sum > $signed({3'b000, maj_delta});
  end

  always_comb begin
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    goal_x_nxt      = goal_x_r;
    goal_y_nxt      = goal_y_r;
    delta_x_nxt     = delta_x_r;
    delta_y_nxt     = delta_y_r;
    step_left_nxt   = step_left_r;
    step_up_nxt     = step_up_r;
    x_major_nxt     = x_major_r;
    line_active_nxt = line_active_r;
    held_color_nxt  = held_color_r;
    accum_error_nxt = accum_error_r;
    push_pixel      = '0;
    if (in_cmd == CMD_START) begin
      held_color_nxt  = in_draw_color;
      cur_x_nxt       = in_x_start;
      cur_y_nxt       = in_y_start;
      goal_x_nxt      = in_x_end;
      goal_y_nxt      = in_y_end;
      step_left_nxt   = in_x_end < in_x_start;
      step_up_nxt     = in_y_end < in_y_start;
      delta_x_nxt     = step_left_nxt ? in_x_start - in_x_end : in_x_end - in_x_start;
      delta_y_nxt     = step_up_nxt ? in_y_start - in_y_end : in_y_end - in_y_start;
      x_major_nxt     = delta_y_nxt <= delta_x_nxt;
      accum_error_nxt = '0;
      line_active_nxt = (delta_x_nxt != '0) || (delta_y_nxt != '0);
      push_pixel.valid = 1'b1;
    end else if (line_active_r) begin
      // Advance the major axis, step the minor one when the error overflows
      if (x_major_r) begin
        cur_x_nxt = step_left_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
        if (minor_step) begin
          cur_y_nxt = step_up_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
        end
        line_active_nxt = cur_x_nxt != goal_x_r;
      end else begin
        cur_y_nxt = step_up_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
        if (minor_step) begin
          cur_x_nxt = step_left_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
        end
        line_active_nxt = cur_y_nxt != goal_y_r;
      end
      accum_error_nxt = minor_step ? err_sum - $signed({2'b00, maj_delta, 1'b0})
                                   : err_sum;
      push_pixel.valid = 1'b1;
    end
    if (push_pixel.valid) begin
      push_pixel.x     = cur_x_nxt;
      push_pixel.y     = cur_y_nxt;
      push_pixel.color = held_color_nxt;
      push_pixel.last  = !line_active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      goal_x_r      <= '0;
      goal_y_r      <= '0;
      delta_x_r     <= '0;
      delta_y_r     <= '0;
      step_left_r   <= 1'b0;
      step_up_r     <= 1'b0;
      x_major_r     <= 1'b0;
      line_active_r <= 1'b0;
      held_color_r  <= 1'b0;
      accum_error_r <= '0;
    end else if (push) begin
      cur_x_r       <= cur_x_nxt;
      cur_y_r       <= cur_y_nxt;
      goal_x_r      <= goal_x_nxt;
      goal_y_r      <= goal_y_nxt;
      delta_x_r     <= delta_x_nxt;
      delta_y_r     <= delta_y_nxt;
      step_left_r   <= step_left_nxt;
      step_up_r     <= step_up_nxt;
      x_major_r     <= x_major_nxt;
      line_active_r <= line_active_nxt;
      held_color_r  <= held_color_nxt;
      accum_error_r <= accum_error_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // Error term stays within plus or minus 255, the largest major delta
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    (accum_error_r >= -$signed(11'sd255)) && (accum_error_r <= $signed(11'sd255)))
    else $error("line error term out of range");

  // A start with equal endpoints leaves the stepper idle
  a_point_idle: assert property (@(posedge clk) disable iff (!rst_n)
    push && (in_cmd == CMD_START) && (in_x_start == in_x_end) && (in_y_start == in_y_end)
    |=> !line_active_r)
    else $error("single point line left stepper active");
`endif

endmodule

// ===== rtl/lpag_queue.sv =====
// ----------------------------------------------------------------------------
// lpag_queue
// Short FIFO of pixel records between the front and the back.
// ----------------------------------------------------------------------------
module lpag_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lpag_pkg::pixel_t push_pixel,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output lpag_pkg::pixel_t head
);
  import lpag_pkg::*;

  pixel_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign full  = count_r == QCNT_W'(QUEUE_DEPTH);
  assign empty = count_r == '0;
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_pixel;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && empty))
    else $error("queue overflow or underflow");
`endif

endmodule

// ===== rtl/lpag_back.sv =====
// ----------------------------------------------------------------------------
// lpag_back
// Holds the display configuration, turns a queued pixel into its display RAM
// byte address and bit position, and drives the registered result.
// ----------------------------------------------------------------------------
module lpag_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [lpag_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpag_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               q_empty,
  input  lpag_pkg::pixel_t                   q_head,
  output logic                               pop,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic                               out_pixel_valid,
  output logic [lpag_pkg::COORD_W-1:0]       out_pixel_x,
  output logic [lpag_pkg::COORD_W-1:0]       out_pixel_y,
  output logic [lpag_pkg::ADDR_W-1:0]        out_byte_address,
  output logic [lpag_pkg::BITPOS_W-1:0]      out_bit_position,
  output logic                               out_set_dot,
  output logic                               out_last_pixel
);
  import lpag_pkg::*;

  logic [ADDR_W-1:0]   graphic_home_r;
  logic [ROWB_W-1:0]   row_bytes_r;
  logic                out_valid_r, out_valid_nxt;
  logic                pix_valid_r, set_dot_r, last_r;
  logic [COORD_W-1:0]  pix_x_r, pix_y_r;
  logic [ADDR_W-1:0]   addr_r, addr_nxt, row_off;
  logic [BITPOS_W-1:0] bitpos_r, bitpos_nxt, x_mod;
  logic [COORD_W-1:0]  col_byte;

  // Configuration writes must only be issued while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      graphic_home_r <= '0;
      row_bytes_r    <= ROW_BYTES_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRAPHIC_HOME: graphic_home_r <= cfg_data;
        REG_ROW_BYTES:    row_bytes_r    <= cfg_data[ROWB_W-1:0];
        default:          ;
      endcase
    end
  end

  assign pop = !q_empty && (!out_valid_r || !out_stall);

  always_comb begin
    col_byte = COORD_W'(q_head.x / COORD_W'(FONT_WIDTH));
    x_mod    = BITPOS_W'(q_head.x % COORD_W'(FONT_WIDTH));
    row_off  = {{(ADDR_W-ROWB_W){1'b0}}, row_bytes_r} * {{(ADDR_W-COORD_W){1'b0}}, q_head.y};
    if (q_head.valid) begin
      addr_nxt   = graphic_home_r + {{(ADDR_W-COORD_W){1'b0}}, col_byte} + row_off;
      bitpos_nxt = BITPOS_W'(FONT_WIDTH - 1) - x_mod;
    end else begin
      addr_nxt   = '0;
      bitpos_nxt = '0;
    end
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pix_valid_r <= q_head.valid;
      pix_x_r     <= q_head.x;
      pix_y_r     <= q_head.y;
      set_dot_r   <= q_head.color;
      last_r      <= q_head.last;
      addr_r      <= addr_nxt;
      bitpos_r    <= bitpos_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_valid  = pix_valid_r;
  assign out_pixel_x      = pix_x_r;
  assign out_pixel_y      = pix_y_r;
  assign out_byte_address = addr_r;
  assign out_bit_position = bitpos_r;
  assign out_set_dot      = set_dot_r;
  assign out_last_pixel   = last_r;

`ifndef NO_ASSERTIONS
  // An invalid result always carries all-zero fields
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !pix_valid_r |-> (addr_r == '0) && (bitpos_r == '0) &&
    (pix_x_r == '0) && (pix_y_r == '0) && !set_dot_r && !last_r)
    else $error("invalid result carries nonzero fields");
`endif

endmodule

// ===== rtl/line_pixel_address_generator_unit.sv =====
// ----------------------------------------------------------------------------
// line_pixel_address_generator_unit
// Bresenham line stepper with display RAM address generation.
// Throughput: one item per cycle while the queue has room; the line stepper
// updates its error term and position as an item is accepted, and the address
// multiply-add is done on the queue head and registered when it is popped.
// Reset (rst_n low, synchronous): stepper idle, queue and output empty,
// graphic_home = 0, row_bytes = 30.
// ----------------------------------------------------------------------------
module line_pixel_address_generator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // item input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [lpag_pkg::COORD_W-1:0]       in_x_start,
  input  logic [lpag_pkg::COORD_W-1:0]       in_y_start,
  input  logic [lpag_pkg::COORD_W-1:0]       in_x_end,
  input  logic [lpag_pkg::COORD_W-1:0]       in_y_end,
  input  logic                               in_draw_color,
  // result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_pixel_valid,
  output logic [lpag_pkg::COORD_W-1:0]       out_pixel_x,
  output logic [lpag_pkg::COORD_W-1:0]       out_pixel_y,
  output logic [lpag_pkg::ADDR_W-1:0]        out_byte_address,
  output logic [lpag_pkg::BITPOS_W-1:0]      out_bit_position,
  output logic                               out_set_dot,
  output logic                               out_last_pixel,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lpag_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpag_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lpag_pkg::*;

  logic   q_full, q_empty, q_push, q_pop;
  pixel_t q_in, q_head;

  // Stall the input only when the queue has no room; the front then
  // holds its state until the item goes in.
  assign in_stall  = q_full;
  // Configuration registers accept a write every cycle
  assign cfg_ready = 1'b1;

  // Front: classify start and step items, advance the line
  lpag_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .q_full        (q_full),
    .in_cmd        (in_cmd),
    .in_x_start    (in_x_start),
    .in_y_start    (in_y_start),
    .in_x_end      (in_x_end),
    .in_y_end      (in_y_end),
    .in_draw_color (in_draw_color),
    .push          (q_push),
    .push_pixel    (q_in)
  );

  // Decouple the stepper from output backpressure
  lpag_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_pixel (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  // Back: compute address and bit position, hold the result register
  lpag_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .pop              (q_pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_pixel_valid  (out_pixel_valid),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_byte_address (out_byte_address),
    .out_bit_position (out_bit_position),
    .out_set_dot      (out_set_dot),
    .out_last_pixel   (out_last_pixel)
  );

endmodule

// ===== tb/sv/line_pixel_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_pixel_checker
// Watches the item, result and register channels of the line pixel address
// generator, keeps its own line stepper, and compares each pixel that leaves
// the block with the one predicted for the oldest accepted item.
// ----------------------------------------------------------------------------
module line_pixel_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [lpag_pkg::COORD_W-1:0]       in_x_start,
  input  logic [lpag_pkg::COORD_W-1:0]       in_y_start,
  input  logic [lpag_pkg::COORD_W-1:0]       in_x_end,
  input  logic [lpag_pkg::COORD_W-1:0]       in_y_end,
  input  logic                               in_draw_color,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic                               out_pixel_valid,
  input  logic [lpag_pkg::COORD_W-1:0]       out_pixel_x,
  input  logic [lpag_pkg::COORD_W-1:0]       out_pixel_y,
  input  logic [lpag_pkg::ADDR_W-1:0]        out_byte_address,
  input  logic [lpag_pkg::BITPOS_W-1:0]      out_bit_position,
  input  logic                               out_set_dot,
  input  logic                               out_last_pixel,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [lpag_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpag_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                 pending_pixels,
  output int                                 mismatch_count
);

  import lpag_pkg::*;

  typedef logic signed [ERR_W-1:0] err_t;

  typedef struct packed {
    logic                pixel_valid;
    logic [COORD_W-1:0]  pixel_x;
    logic [COORD_W-1:0]  pixel_y;
    logic [ADDR_W-1:0]   byte_address;
    logic [BITPOS_W-1:0] bit_position;
    logic                set_dot;
    logic                last_pixel;
  } pixel_expect_t;

  pixel_expect_t expected_pixels[$];

  logic [ADDR_W-1:0]  graphic_home;
  logic [ROWB_W-1:0]  row_bytes;
  logic [COORD_W-1:0] cur_x, cur_y, goal_x, goal_y, delta_x, delta_y;
  logic               step_left, step_up, x_major, line_active, held_color;
  err_t               err_acc;

  initial mismatch_count = 0;

  function automatic pixel_expect_t pixel_at(input logic is_last);
    pixel_expect_t p;
    int unsigned   addr;
    addr = graphic_home + cur_x / FONT_WIDTH + row_bytes * cur_y;
    p.pixel_valid  = 1'b1;
    p.pixel_x      = cur_x;
    p.pixel_y      = cur_y;
    p.byte_address = addr[ADDR_W-1:0];
    p.bit_position = BITPOS_W'(FONT_WIDTH - 1 - cur_x % FONT_WIDTH);
    p.set_dot      = held_color;
    p.last_pixel   = is_last;
    return p;
  endfunction

  // Advance the stepper for one accepted item and queue the pixel it yields.
  function automatic void trace_line();
    if (in_cmd == CMD_START) begin
      held_color  = in_draw_color;
      cur_x       = in_x_start;
      cur_y       = in_y_start;
      goal_x      = in_x_end;
      goal_y      = in_y_end;
      step_left   = in_x_end < in_x_start;
      step_up     = in_y_end < in_y_start;
      delta_x     = step_left ? in_x_start - in_x_end : in_x_end - in_x_start;
      delta_y     = step_up ? in_y_start - in_y_end : in_y_end - in_y_start;
      x_major     = delta_y <= delta_x;
      err_acc     = '0;
      line_active = (delta_x != '0) || (delta_y != '0);
      expected_pixels.push_back(pixel_at(!line_active));
    end else if (!line_active) begin
      expected_pixels.push_back('0);
    end else begin
      if (x_major) begin
        cur_x   = step_left ? cur_x - 1'b1 : cur_x + 1'b1;
        err_acc = err_acc + err_t'({delta_y, 1'b0});
        if (err_acc > err_t'(delta_x)) begin
          cur_y   = step_up ? cur_y - 1'b1 : cur_y + 1'b1;
          err_acc = err_acc - err_t'({delta_x, 1'b0});
        end
        line_active = cur_x != goal_x;
      end else begin
        cur_y   = step_up ? cur_y - 1'b1 : cur_y + 1'b1;
        err_acc = err_acc + err_t'({delta_x, 1'b0});
        if (err_acc > err_t'(delta_y)) begin
          cur_x   = step_left ? cur_x - 1'b1 : cur_x + 1'b1;
          err_acc = err_acc - err_t'({delta_y, 1'b0});
        end
        line_active = cur_y != goal_y;
      end
      expected_pixels.push_back(pixel_at(!line_active));
    end
  endfunction

  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_pixel();
    pixel_expect_t want;
    if (expected_pixels.size() == 0) begin
      $error("pixel result arrived with no item waiting for it");
      mismatch_count++;
    end else begin
      want = expected_pixels.pop_front();
      compare_field("pixel_valid", want.pixel_valid, out_pixel_valid);
      compare_field("pixel_x", want.pixel_x, out_pixel_x);
      compare_field("pixel_y", want.pixel_y, out_pixel_y);
      compare_field("byte_address", want.byte_address, out_byte_address);
      compare_field("bit_position", want.bit_position, out_bit_position);
      compare_field("set_dot", want.set_dot, out_set_dot);
      compare_field("last_pixel", want.last_pixel, out_last_pixel);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      graphic_home = '0;
      row_bytes    = ROW_BYTES_RESET;
      cur_x        = '0;
      cur_y        = '0;
      goal_x       = '0;
      goal_y       = '0;
      delta_x      = '0;
      delta_y      = '0;
      step_left    = 1'b0;
      step_up      = 1'b0;
      x_major      = 1'b0;
      line_active  = 1'b0;
      held_color   = 1'b0;
      err_acc      = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRAPHIC_HOME: graphic_home = cfg_data;
          REG_ROW_BYTES:    row_bytes = cfg_data[ROWB_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_pixel();
      if (in_valid && !in_stall) trace_line();
    end
    pending_pixels <= expected_pixels.size();
  end

endmodule

// ===== tb/sv/line_pixel_address_generator_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_pixel_address_generator_unit_test
// Drives start and step items into the line pixel address generator under
// several display RAM layouts, with random gaps on both channels and one long
// result hold-off, and reports the verdict from the pixel checker.
// ----------------------------------------------------------------------------
module line_pixel_address_generator_unit_test;

  import lpag_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 6;     // extra wait after the last expected pixel is back
  localparam int HOLDOFF      = 60;    // long enough to back up the queue
  localparam int QUIET_LIMIT  = 2000;  // cycles without any handshake

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_cmd;
  logic [COORD_W-1:0]    in_x_start;
  logic [COORD_W-1:0]    in_y_start;
  logic [COORD_W-1:0]    in_x_end;
  logic [COORD_W-1:0]    in_y_end;
  logic                  in_draw_color;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_pixel_valid;
  logic [COORD_W-1:0]    out_pixel_x;
  logic [COORD_W-1:0]    out_pixel_y;
  logic [ADDR_W-1:0]     out_byte_address;
  logic [BITPOS_W-1:0]   out_bit_position;
  logic                  out_set_dot;
  logic                  out_last_pixel;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int pending_pixels;
  int mismatch_count;
  int quiet_cycles = 0;

  // Idling knobs: the sender owns its own, the receiver's is set by NBA.
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  bit holdoff_go     = 1'b0;
  bit holdoff_done   = 1'b0;

  // 10 ns clock, first rising edge at 5 ns
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  line_pixel_address_generator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_x_start       (in_x_start),
    .in_y_start       (in_y_start),
    .in_x_end         (in_x_end),
    .in_y_end         (in_y_end),
    .in_draw_color    (in_draw_color),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_valid  (out_pixel_valid),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_byte_address (out_byte_address),
    .out_bit_position (out_bit_position),
    .out_set_dot      (out_set_dot),
    .out_last_pixel   (out_last_pixel),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  line_pixel_checker pixel_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_x_start       (in_x_start),
    .in_y_start       (in_y_start),
    .in_x_end         (in_x_end),
    .in_y_end         (in_y_end),
    .in_draw_color    (in_draw_color),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_valid  (out_pixel_valid),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_byte_address (out_byte_address),
    .out_bit_position (out_bit_position),
    .out_set_dot      (out_set_dot),
    .out_last_pixel   (out_last_pixel),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pending_pixels   (pending_pixels),
    .mismatch_count   (mismatch_count)
  );

  // Watchdog: end the run when no channel has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    int held;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_go && !holdoff_done) begin
        holdoff_done = 1'b1;
        out_stall <= 1'b1;
        // hold the result channel shut while the sender keeps pushing
        for (held = 0; held < HOLDOFF; held++) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= receiver_idles && ($urandom_range(99) < 31);
      end
    end
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    return COORD_W'($urandom);
  endfunction

  // Pick an endpoint within reach of p, clamped to the screen.
  function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] p,
                                                   input int reach);
    int lo, hi;
    lo = (p > reach) ? p - reach : 0;
    hi = (p + reach > 255) ? 255 : p + reach;
    return COORD_W'($urandom_range(hi, lo));
  endfunction

  // Offer one item; keep valid up until it is taken and leave it up so the
  // next item can follow without a gap.
  task automatic offer(input logic cmd, input logic [COORD_W-1:0] xs, ys, xe, ye,
                       input logic color);
    while (sender_idles && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_x_start    <= xs;
    in_y_start    <= ys;
    in_x_end      <= xe;
    in_y_end      <= ye;
    in_draw_color <= color;
    do @(posedge clk); while (in_stall);
  endtask

  // Step items carry random endpoint fields; the block must ignore them.
  task automatic step_pixels(input int count);
    repeat (count)
      offer(CMD_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
            1'($urandom));
  endtask

  // Drop valid and wait until every expected pixel is back, plus the latency.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Reprogram the display RAM layout while the block is idle.
  task automatic program_layout(input logic [ADDR_W-1:0] home, input logic [ROWB_W-1:0] rows);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= REG_GRAPHIC_HOME;
    cfg_data  <= CFG_DATA_W'(home);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_ROW_BYTES;
    cfg_data  <= CFG_DATA_W'(rows);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly complete lines with random endpoints; some are cut short by a new
  // start, some overrun into idle steps, and a few lone steps act as noise.
  task automatic random_lines(input int budget);
    int sent, kind, reach, major, steps, dx, dy;
    logic [COORD_W-1:0] xs, ys, xe, ye;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(99);
      if (kind < 6) begin
        step_pixels(1);
        sent++;
      end else begin
        xs    = rand_coord();
        ys    = rand_coord();
        reach = (kind < 12) ? 255 : 12;
        xe    = near_coord(xs, reach);
        ye    = near_coord(ys, reach);
        dx    = (xe > xs) ? xe - xs : xs - xe;
        dy    = (ye > ys) ? ye - ys : ys - ye;
        major = (dx > dy) ? dx : dy;
        kind  = $urandom_range(99);
        if (kind < 70)
          steps = major;
        else if (kind < 85)
          steps = (major == 0) ? 0 : $urandom_range(major - 1, 0);
        else
          steps = major + $urandom_range(3, 1);
        offer(CMD_START, xs, ys, xe, ye, 1'($urandom));
        sent++;
        if (steps > budget - sent) steps = budget - sent;
        step_pixels(steps);
        sent += steps;
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= CMD_START;
    in_x_start    <= '0;
    in_y_start    <= '0;
    in_x_end      <= '0;
    in_y_end      <= '0;
    in_draw_color <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_GRAPHIC_HOME;
    cfg_data      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines under the reset layout.
    // A step with no line running gives an empty pixel.
    step_pixels(1);
    // Single point line at the far corner: last at once, block stays idle.
    offer(CMD_START, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    step_pixels(1);
    // Shallow line to the right, then one step past its end.
    offer(CMD_START, 8'd0, 8'd0, 8'd3, 8'd1, 1'b0);
    step_pixels(4);
    // Steep line up and to the left from the corner.
    offer(CMD_START, 8'd255, 8'd255, 8'd253, 8'd250, 1'b1);
    step_pixels(5);
    // Equal deltas: x is the major axis.
    offer(CMD_START, 8'd10, 8'd10, 8'd12, 8'd12, 1'b0);
    step_pixels(2);
    // Abandon a running line with a new start.
    offer(CMD_START, 8'd100, 8'd100, 8'd200, 8'd150, 1'b1);
    step_pixels(2);
    offer(CMD_START, 8'd7, 8'd200, 8'd5, 8'd200, 1'b1);
    step_pixels(2);

    // Top of RAM with the widest rows: addresses wrap at 16 bits.
    program_layout(16'hFFFF, 8'd255);
    random_lines(170);

    // Bottom of RAM with single byte rows.
    program_layout(16'h0000, 8'd1);
    random_lines(170);

    // Full rate on both sides, and one long result hold-off up front.
    program_layout(ADDR_W'($urandom), ROWB_W'($urandom_range(255, 1)));
    sender_idles = 1'b0;
    receiver_idles <= 1'b0;
    holdoff_go     <= 1'b1;
    random_lines(180);

    sender_idles = 1'b1;
    receiver_idles <= 1'b1;
    program_layout(ADDR_W'($urandom), ROWB_W'($urandom_range(255, 1)));
    random_lines(180);

    drain();
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lpag_pkg.sv
rtl/lpag_front.sv
rtl/lpag_queue.sv
rtl/lpag_back.sv
rtl/line_pixel_address_generator_unit.sv
tb/sv/line_pixel_checker.sv
tb/sv/line_pixel_address_generator_unit_test.sv
